>>> hw/rtl/sobel_gradient_magnitude_direction_assert.svh
// assertion macros for the sobel gradient block
`ifndef SOBEL_GRADIENT_MAGNITUDE_DIRECTION_ASSERT_SVH
`define SOBEL_GRADIENT_MAGNITUDE_DIRECTION_ASSERT_SVH
`ifndef ASSERT_OFF
`define SGMD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sgmd assertion failed");
`define SGMD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sgmd assertion failed");
`else
`define SGMD_ASSERT(lbl, prop)
`define SGMD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> hw/rtl/sgmd_pkg.sv
`default_nettype none
package sgmd_pkg;

  localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [31:0] DEG_180_Q16 = 32'sd11796480;
  localparam logic signed [31:0] DEG_360_Q16 = 32'sd23592960;
  localparam logic signed [22:0] DEG_360_Q6  = 23'sd23040;
  localparam logic signed [22:0] ANGLE_MAX   = 23'sd11520;
  localparam logic signed [14:0] ANGLE_PI    = 15'sd11520;
  localparam logic signed [14:0] ANGLE_HALF  = 15'sd5760;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_LOAD,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_RUN,
    BK_FINISH
  } back_state_t;

  typedef struct packed {
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [15:0]        row;
    logic [9:0]         col;
    logic               last;
  } qentry_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sgmd_ram.sv
`default_nettype none
module sgmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/sgmd_front.sv
`default_nettype none
module sgmd_front #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [10:0]     line_width,
  input  wire logic [15:0]     frame_height,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      pixel,
  input  wire logic            frame_start,
  input  wire logic            q_full,
  output logic                 q_push,
  output sgmd_pkg::qentry_t    q_data
);
  import sgmd_pkg::*;

  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int WW = CW + 1;

  front_state_t state, state_next;

  logic [CW-1:0] col;
  logic [15:0]   row;
  logic [CW-1:0] c_cur;
  logic [15:0]   r_cur;
  logic [7:0]    px;
  logic [7:0]    win [3][3];
  qentry_t       entry;

  logic [WW-1:0] w;
  logic [15:0]   h;
  logic [CW-1:0] c0, c1;
  logic [16:0]   r0, r1;
  logic [7:0]    top, mid;
  logic [7:0]    rd_a, rd_b;
  logic [9:0]    sum_r, sum_l, sum_t, sum_b;
  logic [WW-1:0] c_inc;
  logic [16:0]   r_inc;
  logic          load_en;

  always_comb begin
    if ({21'd0, line_width} < 32'd3) begin
      w = WW'(3);
    end else if ({21'd0, line_width} > 32'(MAX_LINE_WIDTH)) begin
      w = WW'(MAX_LINE_WIDTH);
    end else begin
      w = WW'(line_width);
    end
    h = (frame_height < 16'd3) ? 16'd3 : frame_height;
  end

  // position of the incoming pixel, with wrap after a size change
  always_comb begin
    c0 = frame_start ? '0 : col;
    r0 = frame_start ? 17'd0 : {1'b0, row};
    c1 = c0;
    r1 = r0;
    if ({1'b0, c0} >= w) begin
      c1 = '0;
      r1 = r0 + 17'd1;
    end
    if (r1 >= {1'b0, h}) begin
      r1 = 17'd0;
    end
  end

  assign load_en = (state == FR_LOAD);
  assign top = rd_b;
  assign mid = rd_a;

  sgmd_ram #(.WIDTH(8), .DEPTH(MAX_LINE_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (load_en),
    .waddr (c_cur),
    .wdata (px),
    .raddr (c1),
    .rdata (rd_a)
  );

  sgmd_ram #(.WIDTH(8), .DEPTH(MAX_LINE_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (load_en),
    .waddr (c_cur),
    .wdata (mid),
    .raddr (c1),
    .rdata (rd_b)
  );

  // sums over the shifted window
  always_comb begin
    sum_r = {2'd0, top} + {1'd0, mid, 1'b0} + {2'd0, px};
    sum_l = {2'd0, win[0][1]} + {1'd0, win[1][1], 1'b0} + {2'd0, win[2][1]};
    sum_t = {2'd0, win[0][1]} + {1'd0, win[0][2], 1'b0} + {2'd0, top};
    sum_b = {2'd0, win[2][1]} + {1'd0, win[2][2], 1'b0} + {2'd0, px};
    c_inc = {1'b0, c_cur} + WW'(1);
    r_inc = {1'b0, r_cur} + 17'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      if (load_en) begin
        if (c_inc >= w) begin
          col <= '0;
          row <= (r_inc >= {1'b0, h}) ? 16'd0 : r_inc[15:0];
        end else begin
          col <= c_inc[CW-1:0];
          row <= r_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == FR_IDLE && in_valid) begin
      px    <= pixel;
      c_cur <= c1;
      r_cur <= r1[15:0];
    end
    if (load_en) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2]  <= top;
      win[1][2]  <= mid;
      win[2][2]  <= px;
      entry.gx   <= $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
      entry.gy   <= $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
      entry.row  <= r_cur - 16'd1;
      entry.col  <= 10'(c_cur - CW'(1));
      entry.last <= (r_cur == h - 16'd1) && ({1'b0, c_cur} == w - WW'(1));
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    q_push     = 1'b0;
    case (state)
      FR_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = FR_LOAD;
        end
      end
      FR_LOAD: begin
        if ({1'b0, c_cur} >= WW'(2) && r_cur >= 16'd2) begin
          state_next = FR_PUSH;
        end else begin
          state_next = FR_IDLE;
        end
      end
      FR_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  assign q_data = entry;
endmodule
`default_nettype wire

>>> hw/rtl/sgmd_queue.sv
`default_nettype none
module sgmd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sgmd_pkg::qentry_t wdata,
  output logic                   full,
  input  wire logic              pop,
  output sgmd_pkg::qentry_t      rdata,
  output logic                   empty
);
  import sgmd_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  qentry_t       slots [QUEUE_DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + AW'(1);
      end
      if (pop) begin
        rptr <= rptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/sgmd_back.sv
`default_nettype none
module sgmd_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire sgmd_pkg::qentry_t q_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [10:0]     grad_x,
  output logic signed [10:0]     grad_y,
  output logic [14:0]            magnitude,
  output logic signed [14:0]     angle,
  output logic [15:0]            center_row,
  output logic [9:0]             center_col,
  output logic                   last
);
  import sgmd_pkg::*;

  localparam int SQRT_STEPS = 15;
  localparam int ITER = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int KW   = $clog2(ITER + 1);

  back_state_t state, state_next;

  qentry_t            e;
  logic [KW-1:0]      k;
  logic [29:0]        nsh;
  logic [17:0]        rem;
  logic [14:0]        root;
  logic signed [31:0] x, y, z;

  logic [20:0]        sqx, sqy;
  logic [21:0]        sq_sum;
  logic signed [20:0] gx_ext, gy_ext;
  logic signed [31:0] gx_q16, gy_q16;
  logic [17:0]        rem_sh, trial;
  logic signed [31:0] xs, ys;
  logic [31:0]        zt;
  logic signed [22:0] r;
  logic signed [14:0] ang;
  logic               fin_go;

  always_comb begin
    gx_ext = {{10{e.gx[10]}}, e.gx};
    gy_ext = {{10{e.gy[10]}}, e.gy};
    sqx    = 21'(gx_ext * gx_ext);
    sqy    = 21'(gy_ext * gy_ext);
    sq_sum = {1'b0, sqx} + {1'b0, sqy};
    gx_q16 = {{5{e.gx[10]}}, e.gx, 16'd0};
    gy_q16 = {{5{e.gy[10]}}, e.gy, 16'd0};
    rem_sh = {rem[15:0], nsh[29:28]};
    trial  = {1'b0, root, 2'b01};
    xs     = x >>> k;
    ys     = y >>> k;
    zt     = 32'(z + DEG_360_Q16 + 32'sd512);
    r      = $signed({1'b0, zt[31:10]}) - DEG_360_Q6;
    if (e.gy == '0) begin
      ang = e.gx[10] ? ANGLE_PI : '0;
    end else if (e.gx == '0) begin
      ang = e.gy[10] ? -ANGLE_HALF : ANGLE_HALF;
    end else if (r > ANGLE_MAX) begin
      ang = ANGLE_PI;
    end else if (r < -ANGLE_MAX) begin
      ang = -ANGLE_PI;
    end else begin
      ang = 15'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          e <= q_data;
        end
      end
      BK_SQUARE: begin
        nsh  <= {sq_sum[21:0], 8'd0};
        rem  <= '0;
        root <= '0;
        k    <= '0;
        if (e.gx[10]) begin
          x <= -gx_q16;
          y <= -gy_q16;
          z <= e.gy[10] ? -DEG_180_Q16 : DEG_180_Q16;
        end else begin
          x <= gx_q16;
          y <= gy_q16;
          z <= '0;
        end
      end
      BK_RUN: begin
        k <= k + KW'(1);
        if (k < KW'(SQRT_STEPS)) begin
          nsh <= {nsh[27:0], 2'b00};
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[13:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[13:0], 1'b0};
          end
        end
        if (k < KW'(CORDIC_STEPS)) begin
          if (!y[31]) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + atan_deg(5'(k));
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - atan_deg(5'(k));
          end
        end
      end
      default: ;
    endcase
    if (fin_go) begin
      grad_x     <= e.gx;
      grad_y     <= e.gy;
      magnitude  <= root + ((rem > {3'd0, root}) ? 15'd1 : 15'd0);
      angle      <= ang;
      center_row <= e.row;
      center_col <= e.col;
      last       <= e.last;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    fin_go     = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BK_SQUARE;
        end
      end
      BK_SQUARE: state_next = BK_RUN;
      BK_RUN: begin
        if (k == KW'(ITER - 1)) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (!out_valid || out_ready) begin
          fin_go     = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/sobel_gradient_magnitude_direction.sv
// Sobel 3x3 gradient, magnitude and angle over a raster grayscale stream.
// Input stream: s_tdata[7:0] is the pixel, s_tuser marks the first pixel of
// a frame. Output stream: one transaction per interior pixel with gx, gy,
// magnitude (4 fraction bits), angle in degrees (6 fraction bits) and the
// window center position; m_tlast flags the last interior result of a frame.
// Border pixels give no output transaction.
// Front end takes a new pixel only after the line-store read and write-back of
// the last one, and after it has pushed that pixel's result when it makes one.
// Back end works on one result at a time in its shared square-root and CORDIC
// iteration loop and takes the next queue entry once that result has gone to
// the output register. A 4-entry queue between the two parts lets pixels keep
// flowing while the back end works.
// cfg_we writes line_width (index 0) or frame_height (index 1); write only
// while idle. Reset clears the counters and sets 640 by 480; line stores are
// not cleared. A stalled m_tready holds the result and fills the queue, after
// which s_tready drops.
`default_nettype none
module sobel_gradient_magnitude_direction #(
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int CORDIC_STEPS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // pixel
  input  wire logic        s_tuser,  // frame_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // grad_x, grad_y, magnitude, angle, center_row, center_col, zero fill
  output logic [79:0]      m_tdata,
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import sgmd_pkg::*;

  `include "sobel_gradient_magnitude_direction_assert.svh"

  logic [10:0]        line_width;
  logic [15:0]        frame_height;
  logic               q_push, q_pop, q_full, q_empty;
  qentry_t            q_wdata, q_rdata;
  logic signed [10:0] grad_x, grad_y;
  logic [14:0]        magnitude;
  logic signed [14:0] angle;
  logic [15:0]        center_row;
  logic [9:0]         center_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= 11'd640;
      frame_height <= 16'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH:   line_width   <= cfg_data[10:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  sgmd_front #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .line_width   (line_width),
    .frame_height (frame_height),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .pixel        (s_tdata),
    .frame_start  (s_tuser),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  sgmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sgmd_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_rdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .grad_x     (grad_x),
    .grad_y     (grad_y),
    .magnitude  (magnitude),
    .angle      (angle),
    .center_row (center_row),
    .center_col (center_col),
    .last       (m_tlast)
  );

  assign m_tdata = {2'b00, center_col, center_row, angle, magnitude, grad_y, grad_x};

  `SGMD_ASSERT(a_no_overflow, q_push |-> !q_full)
  `SGMD_ASSERT(a_no_underflow, q_pop |-> !q_empty)
  `SGMD_ASSERT(a_front_busy, (s_tvalid && s_tready) |=> !s_tready)
  `SGMD_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !m_tvalid)
endmodule
`default_nettype wire

>>> sim/sobel_gradient_checker.sv
module sobel_gradient_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import sgmd_pkg::*;

  typedef struct packed {
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [14:0]        mag;
    logic signed [14:0] ang;
    logic [15:0]        row;
    logic [9:0]         col;
    logic               last;
  } gradient_t;

  gradient_t gradient_q[$];
  logic [7:0] row_prev[1024];
  logic [7:0] row_prev2[1024];
  logic [7:0] win[3][3];
  int unsigned col_pos, row_pos, width_reg, height_reg;

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [14:0] magnitude_q4(int gx, int gy);
    longint unsigned n, s, t, b;
    n = (longint'(gx) * gx + longint'(gy) * gy) << 8;
    s = 0;
    for (b = 64'd1 << 30; b != 0; b >>= 1) begin
      t = s | b;
      if (t * t <= n) s = t;
    end
    if (n > s * s + s) s++;
    return s[14:0];
  endfunction

  function automatic logic signed [14:0] angle_q6(int gx, int gy);
    longint x, y, z, r, xs, ys, tab;
    if (gy == 0) return gx < 0 ? 15'sd11520 : 15'sd0;
    if (gx == 0) return gy > 0 ? 15'sd5760 : -15'sd5760;
    x = longint'(gx) * 65536;
    y = longint'(gy) * 65536;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = sra(x, i);
      ys = sra(y, i);
      tab = atan_deg(i[4:0]);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += tab;
      end else begin
        x = x - ys; y = y + xs; z -= tab;
      end
    end
    r = ((z + 360 * 65536 + 512) >>> 10) - 360 * 64;
    if (r > 11520) r = 11520;
    if (r < -11520) r = -11520;
    return r[14:0];
  endfunction

  task automatic advance_pixel(logic [7:0] px, logic fs);
    int unsigned w, h, c, r;
    logic [7:0] top, mid;
    int gx, gy;
    gradient_t g;
    w = width_reg < 3 ? 3 : (width_reg > 1024 ? 1024 : width_reg);
    h = height_reg < 3 ? 3 : height_reg;
    if (fs) begin
      col_pos = 0; row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0; row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos; r = row_pos;
    top = row_prev2[c];
    mid = row_prev[c];
    row_prev2[c] = mid;
    row_prev[c] = px;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top; win[1][2] = mid; win[2][2] = px;
    if (c >= 2 && r >= 2) begin
      gx = win[0][2] + 2 * win[1][2] + win[2][2] - win[0][0] - 2 * win[1][0] - win[2][0];
      gy = win[0][0] + 2 * win[0][1] + win[0][2] - win[2][0] - 2 * win[2][1] - win[2][2];
      g.gx = gx[10:0];
      g.gy = gy[10:0];
      g.mag = magnitude_q4(gx, gy);
      g.ang = angle_q6(gx, gy);
      g.row = 16'(r - 1);
      g.col = 10'(c - 1);
      g.last = (r == h - 1 && c == w - 1);
      gradient_q.push_back(g);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic compare_result();
    gradient_t e, a;
    a.gx = m_tdata[10:0];
    a.gy = m_tdata[21:11];
    a.mag = m_tdata[36:22];
    a.ang = m_tdata[51:37];
    a.row = m_tdata[67:52];
    a.col = m_tdata[77:68];
    a.last = m_tlast;
    if (gradient_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result %h", a);
    end else begin
      e = gradient_q.pop_front();
      if (a !== e || m_tdata[79:78] !== 2'b00) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch gx %0d/%0d gy %0d/%0d mag %0d/%0d ang %0d/%0d row %0d/%0d col %0d/%0d last %0d/%0d",
                   e.gx, a.gx, e.gy, a.gy, e.mag, a.mag, e.ang, a.ang,
                   e.row, a.row, e.col, a.col, e.last, a.last);
      end
    end
  endtask

  assign pending = gradient_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      col_pos = 0; row_pos = 0;
      width_reg = 640; height_reg = 480;
      gradient_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_LINE_WIDTH) width_reg = cfg_data & 16'h7ff;
        else if (cfg_index == REG_FRAME_HEIGHT) height_reg = cfg_data;
      end
      if (s_tvalid && s_tready) advance_pixel(s_tdata, s_tuser);
      if (m_tvalid && m_tready) compare_result();
    end
  end
endmodule

>>> sim/tb_sobel_gradient_magnitude_direction.sv
module tb_sobel_gradient_magnitude_direction;
  import sgmd_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [7:0] s_tdata = 0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [79:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_LINE_WIDTH;
  logic [15:0] cfg_data = 0;
  int fail_count, pending;
  bit calm;

  sobel_gradient_magnitude_direction dut (.*);

  sobel_gradient_checker chk (.*);

  initial forever #10 clk = ~clk;

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= calm || ($urandom_range(99) >= 23);
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_pixel(logic [7:0] px, logic fs);
    while (!calm && $urandom_range(99) < 23) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1; s_tdata <= px; s_tuser <= fs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_frame(int w, int h, int mode);
    logic [7:0] px;
    for (int i = 0; i < w * h; i++) begin
      case (mode)
        0: px = $urandom;
        1: px = (i % 2) ? 8'hff : 8'h00;
        2: px = ((i / w) % 2) ? 8'hff : 8'h00;
        default: px = ($urandom_range(1)) ? 8'hff : 8'h00;
      endcase
      send_pixel(px, i == 0 || ($urandom_range(199) == 0));
    end
  endtask

  initial begin
    int w, h;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_reg(REG_LINE_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    calm = 1;
    for (int i = 0; i < 9; i++) send_pixel(i < 4 ? 8'hff : 8'h00, i == 0);
    for (int i = 0; i < 9; i++) send_pixel(8'hff, i == 0);
    drain();
    write_reg(REG_LINE_WIDTH, 4);
    write_reg(REG_FRAME_HEIGHT, 3);
    send_frame(4, 3, 1);
    drain();
    calm = 0;
    for (int f = 0; f < 40; f++) begin
      calm = (f >= 10 && f < 14);
      case ($urandom_range(4))
        0: begin w = 3; h = 3; end
        default: begin w = $urandom_range(3, 8); h = $urandom_range(3, 5); end
      endcase
      if (f == 20) begin w = 2047; h = 1; end
      if (f == 21) begin w = 0; h = 1; end
      write_reg(REG_LINE_WIDTH, w[15:0]);
      write_reg(REG_FRAME_HEIGHT, h[15:0]);
      if (f == 21) begin w = 3; h = 3; end
      if (f == 30) write_reg(2'd3, 16'hffff);
      send_frame(f == 20 ? 48 : w, f == 20 ? 1 : h, $urandom_range(3));
      drain();
    end
    write_reg(REG_FRAME_HEIGHT, 16'hffff);
    write_reg(REG_LINE_WIDTH, 5);
    send_frame(5, 6, 0);
    drain();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
